[rtl/otss_pkg.sv]
// Package: shared constants and types of the order table core.
package otss_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_CANCEL   = 3'd1;
    localparam logic [2:0] CMD_GET      = 3'd2;
    localparam logic [2:0] CMD_SNAPSHOT = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SEL_RD,
        S_SEL_CHK,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_OUT
    } state_t;

    // slot entry as stored
    typedef struct packed {
        logic [63:0] id;
        logic [31:0] price;
        logic [31:0] quantity;
        logic        side;
    } entry_t;

    // true when a sorts before b
    function automatic logic goes_before(entry_t a, entry_t b);
        logic r;
        begin
            if (a.side != b.side)
                r = (a.side == 1'b0);
            else if (a.price != b.price)
                r = a.side ? (a.price < b.price) : (a.price > b.price);
            else
                r = (a.id < b.id);
            return r;
        end
    endfunction

endpackage

[rtl/otss_store.sv]
// Slot store: order memory with one read and one write port.
module otss_store
    import otss_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [CAPACITY];

    // registered read, single write
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[rtl/order_table_with_sorted_snapshot_core.sv]
// Top level: order table with id search, add/cancel/get and sorted snapshot.
//
//  channel | handshake            | fields
//  in      | in_valid, in_stall   | command, ord_key, price, quantity, side
//  out     | out_valid, out_stall | status, ord_key_res, price/quantity/side_res, last, counts
//
// Add/cancel: each slot is searched in a read and a compare state, then the table is
// updated and the output register loaded; get adds a state that reads the stored entry.
// Snapshot: each emitted order costs a full selection scan over all slots.
// Clear and unused commands go straight to the output register. Reset empties the table
// at once (valid bits). in_stall is high while busy and while a result waits under out_stall.
module order_table_with_sorted_snapshot_core
    import otss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       command,
    input  logic [63:0]      ord_key,
    input  logic [31:0]      price,
    input  logic [31:0]      quantity,
    input  logic             side,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic [63:0]      ord_key_res,
    output logic [31:0]      price_res,
    output logic [31:0]      quantity_res,
    output logic             side_res,
    output logic             last,
    output logic [CNT_W-1:0] active_count,
    output logic [31:0]      added_total,
    output logic [31:0]      cancelled_total
);

    state_t state_reg, state_next;

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [31:0]         add_cnt_reg, add_cnt_next;
    logic [31:0]         can_cnt_reg, can_cnt_next;

    logic [2:0]   cmd_reg, cmd_next;
    entry_t       req_reg, req_next;
    logic [IDX_W:0] idx_reg, idx_next;
    logic         found_reg, found_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    // snapshot: last emitted entry and current best candidate
    entry_t       prev_reg, prev_next;
    logic         have_prev_reg, have_prev_next;
    entry_t       best_reg, best_next;
    logic         have_best_reg, have_best_next;
    logic [IDX_W:0] emitted_reg, emitted_next;

    logic         ov_reg, ov_next;
    logic [2:0]   st_reg, st_next;
    entry_t       res_reg, res_next;
    logic         last_reg, last_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t           rdata;
    logic [IDX_W-1:0] cur;
    logic             out_free;
    logic [IDX_W-1:0] free_slot;
    logic             free_any;

    otss_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (req_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cur      = idx_reg[IDX_W-1:0];
    assign out_free = !ov_reg || !out_stall;

    // lowest free slot from valid bits
    always_comb
    begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = IDX_W'(i);
                free_any  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            live_reg    <= '0;
            add_cnt_reg <= '0;
            can_cnt_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            live_reg    <= live_next;
            add_cnt_reg <= add_cnt_next;
            can_cnt_reg <= can_cnt_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        hit_reg       <= hit_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        best_reg      <= best_next;
        have_best_reg <= have_best_next;
        emitted_reg   <= emitted_next;
        st_reg        <= st_next;
        res_reg       <= res_next;
        last_reg      <= last_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        live_next      = live_reg;
        add_cnt_next   = add_cnt_reg;
        can_cnt_next   = can_cnt_reg;
        cmd_next       = cmd_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        best_next      = best_reg;
        have_best_next = have_best_reg;
        emitted_next   = emitted_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        ov_next        = ov_reg && out_stall;
        in_stall       = 1'b1;
        we             = 1'b0;
        waddr          = free_slot;
        raddr          = cur;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    cmd_next       = command;
                    req_next       = '{id: ord_key, price: price,
                                       quantity: quantity, side: side};
                    idx_next       = '0;
                    found_next     = 1'b0;
                    have_prev_next = 1'b0;
                    have_best_next = 1'b0;
                    emitted_next   = '0;
                    res_next       = '0;
                    last_next      = 1'b1;
                    st_next        = ST_OK;
                    case (command)
                        CMD_ADD, CMD_CANCEL, CMD_GET: state_next = S_SCAN_RD;
                        CMD_SNAPSHOT:                 state_next = S_SEL_RD;
                        CMD_CLEAR:
                        begin
                            valid_next   = '0;
                            live_next    = '0;
                            add_cnt_next = '0;
                            can_cnt_next = '0;
                            state_next   = S_OUT;
                        end
                        default:                      state_next = S_OUT;
                    endcase
                end
            end

            // id search: read slot, then compare
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (valid_reg[cur] && rdata.id == req_reg.id && !found_reg)
                begin
                    found_next = 1'b1;
                    hit_next   = cur;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (IDX_W+1)'(CAPACITY - 1))
                    state_next = S_EMIT_RD;
                else
                    state_next = S_SCAN_RD;
            end

            // selection pass: smallest entry that follows the previous one
            S_SEL_RD:
            begin
                state_next = S_SEL_CHK;
            end

            S_SEL_CHK:
            begin
                if (valid_reg[cur] && (!have_prev_reg || goes_before(prev_reg, rdata))
                    && (!have_best_reg || goes_before(rdata, best_reg)))
                begin
                    best_next      = rdata;
                    have_best_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (IDX_W+1)'(CAPACITY - 1))
                    state_next = S_EMIT_RD;
                else
                    state_next = S_SEL_RD;
            end

            // finish an item or a snapshot step
            S_EMIT_RD:
            begin
                state_next = S_OUT;
                if (cmd_reg == CMD_SNAPSHOT)
                begin
                    if (!have_best_reg)
                    begin
                        st_next  = ST_EMPTY;
                        res_next = '0;
                    end
                    else
                    begin
                        res_next       = best_reg;
                        prev_next      = best_reg;
                        have_prev_next = 1'b1;
                        emitted_next   = emitted_reg + 1'b1;
                        last_next      = ((emitted_reg + 1'b1) == {1'b0, live_reg[IDX_W-1:0]})
                                         || ((CNT_W)'(emitted_reg + 1'b1) == live_reg);
                    end
                end
                else if (cmd_reg == CMD_ADD)
                begin
                    if (found_reg)
                        st_next = ST_DUP;
                    else if (live_reg >= CNT_W'(CAPACITY) || !free_any)
                        st_next = ST_FULL;
                    else
                    begin
                        we                    = 1'b1;
                        valid_next[free_slot] = 1'b1;
                        live_next             = live_reg + 1'b1;
                        if (add_cnt_reg != CNT_MAX)
                            add_cnt_next = add_cnt_reg + 1'b1;
                    end
                end
                else if (cmd_reg == CMD_CANCEL)
                begin
                    if (!found_reg)
                        st_next = ST_NOTFOUND;
                    else
                    begin
                        valid_next[hit_reg] = 1'b0;
                        if (live_reg != '0)
                            live_next = live_reg - 1'b1;
                        if (can_cnt_reg != CNT_MAX)
                            can_cnt_next = can_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    raddr = hit_reg;
                    if (!found_reg)
                        st_next = ST_NOTFOUND;
                    else
                        state_next = S_EMIT_WAIT;
                end
            end

            // get: stored entry arrives from read port
            S_EMIT_WAIT:
            begin
                res_next   = rdata;
                state_next = S_OUT;
            end

            // present result once the output register is free
            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (cmd_reg == CMD_SNAPSHOT && st_reg == ST_OK && !last_reg)
                    begin
                        idx_next       = '0;
                        have_best_next = 1'b0;
                        state_next     = S_SEL_RD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // output register: loaded on S_OUT transfer, counts sampled then
    logic [2:0]       o_st_reg;
    entry_t           o_res_reg;
    logic             o_last_reg;
    logic [CNT_W-1:0] o_live_reg;
    logic [31:0]      o_add_reg, o_can_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            o_st_reg   <= st_reg;
            o_res_reg  <= res_reg;
            o_last_reg <= last_reg;
            o_live_reg <= live_reg;
            o_add_reg  <= add_cnt_reg;
            o_can_reg  <= can_cnt_reg;
        end
    end

    assign out_valid       = ov_reg;
    assign status          = o_st_reg;
    assign ord_key_res     = o_res_reg.id;
    assign price_res       = o_res_reg.price;
    assign quantity_res    = o_res_reg.quantity;
    assign side_res        = o_res_reg.side;
    assign last            = o_last_reg;
    assign active_count    = o_live_reg;
    assign added_total     = o_add_reg;
    assign cancelled_total = o_can_reg;

endmodule

[verif/tb.sv]
// Testbench for the order table core: scoreboard with its own table model.
`timescale 1ns / 1ps

module tb;
    import otss_pkg::*;

    // one result transfer
    typedef struct {
        logic [2:0]       status;
        logic [63:0]      id;
        logic [31:0]      price;
        logic [31:0]      quantity;
        logic             side;
        logic             last;
        logic [CNT_W-1:0] active;
        logic [31:0]      added;
        logic [31:0]      cancelled;
    } report_t;

    // Table model and queue of expected reports
    class order_book_scoreboard;
        bit          live   [CAPACITY];
        logic [63:0] ids    [CAPACITY];
        logic [31:0] prices [CAPACITY];
        logic [31:0] qtys   [CAPACITY];
        logic        sides  [CAPACITY];
        int unsigned n_live;
        logic [31:0] n_added;
        logic [31:0] n_cancelled;
        report_t     pending_reports[$];
        int unsigned mismatches;
        int unsigned n_checked;
        int unsigned n_full_seen;
        int unsigned n_dup_seen;
        int unsigned n_snap_rows;

        function new();
            foreach (live[i]) live[i] = 0;
            n_live = 0;
            n_added = 0;
            n_cancelled = 0;
            mismatches = 0;
            n_checked = 0;
            n_full_seen = 0;
            n_dup_seen = 0;
            n_snap_rows = 0;
        endfunction

        function int locate(logic [63:0] key);
            for (int i = 0; i < CAPACITY; i++)
                if (live[i] && ids[i] == key)
                    return i;
            return -1;
        endfunction

        // sort rule: buys first (price down), sells (price up), then id up
        function bit ranks_ahead(int a, int b);
            if (sides[a] != sides[b])
                return sides[a] == 1'b0;
            if (prices[a] != prices[b])
                return sides[a] ? (prices[a] < prices[b]) : (prices[a] > prices[b]);
            return ids[a] < ids[b];
        endfunction

        function void push_report(logic [2:0] st, int slot, bit fin);
            report_t r;
            r.status = st;
            r.id = (slot >= 0) ? ids[slot] : '0;
            r.price = (slot >= 0) ? prices[slot] : '0;
            r.quantity = (slot >= 0) ? qtys[slot] : '0;
            r.side = (slot >= 0) ? sides[slot] : 1'b0;
            r.last = fin;
            r.active = n_live[CNT_W-1:0];
            r.added = n_added;
            r.cancelled = n_cancelled;
            pending_reports = {pending_reports, r};
        endfunction

        // accepted command: update the table and queue what it must report
        function void note_command(logic [2:0] cmd, logic [63:0] key, logic [31:0] pr,
                                   logic [31:0] qty, logic sd);
            int s;
            int order[$];
            int j;
            case (cmd)
                CMD_ADD:
                begin
                    if (locate(key) >= 0)
                    begin
                        n_dup_seen++;
                        push_report(ST_DUP, -1, 1);
                    end
                    else if (n_live >= CAPACITY)
                    begin
                        n_full_seen++;
                        push_report(ST_FULL, -1, 1);
                    end
                    else
                    begin
                        s = 0;
                        while (live[s]) s++;
                        live[s] = 1;
                        ids[s] = key;
                        prices[s] = pr;
                        qtys[s] = qty;
                        sides[s] = sd;
                        n_live++;
                        if (n_added != CNT_MAX) n_added++;
                        push_report(ST_OK, -1, 1);
                    end
                end
                CMD_CANCEL:
                begin
                    s = locate(key);
                    if (s < 0)
                        push_report(ST_NOTFOUND, -1, 1);
                    else
                    begin
                        live[s] = 0;
                        n_live--;
                        if (n_cancelled != CNT_MAX) n_cancelled++;
                        push_report(ST_OK, -1, 1);
                    end
                end
                CMD_GET:
                begin
                    s = locate(key);
                    push_report((s < 0) ? ST_NOTFOUND : ST_OK, s, 1);
                end
                CMD_SNAPSHOT:
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (!live[i]) continue;
                        j = order.size();
                        order = {order, i};
                        while (j > 0 && ranks_ahead(i, order[j-1]))
                        begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = i;
                    end
                    if (order.size() == 0)
                        push_report(ST_EMPTY, -1, 1);
                    foreach (order[k])
                    begin
                        n_snap_rows++;
                        push_report(ST_OK, order[k], k == order.size() - 1);
                    end
                end
                CMD_CLEAR:
                begin
                    foreach (live[i]) live[i] = 0;
                    n_live = 0;
                    n_added = 0;
                    n_cancelled = 0;
                    push_report(ST_OK, -1, 1);
                end
                default: push_report(ST_OK, -1, 1);
            endcase
        endfunction

        function void field_diff(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: report %0d field %s expected %0h got %0h",
                             n_checked, name, want, got);
            end
        endfunction

        // accepted result: compare with the oldest expected report
        function void check_report(report_t got);
            report_t want;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result, status %0d id %0h",
                             got.status, got.id);
                return;
            end
            want = pending_reports.pop_front();
            field_diff("status", want.status, got.status);
            field_diff("ord_key_res", want.id, got.id);
            field_diff("price_res", want.price, got.price);
            field_diff("quantity_res", want.quantity, got.quantity);
            field_diff("side_res", want.side, got.side);
            field_diff("last", want.last, got.last);
            field_diff("active_count", want.active, got.active);
            field_diff("added_total", want.added, got.added);
            field_diff("cancelled_total", want.cancelled, got.cancelled);
            n_checked++;
        endfunction
    endclass

    localparam int WATCHDOG_CYCLES = 60000;
    localparam int ID_POOL = 96;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [2:0]       command;
    logic [63:0]      ord_key;
    logic [31:0]      price;
    logic [31:0]      quantity;
    logic             side;
    logic             out_valid;
    logic             out_stall;
    logic [2:0]       status;
    logic [63:0]      ord_key_res;
    logic [31:0]      price_res;
    logic [31:0]      quantity_res;
    logic             side_res;
    logic             last;
    logic [CNT_W-1:0] active_count;
    logic [31:0]      added_total;
    logic [31:0]      cancelled_total;

    order_book_scoreboard book;
    logic [63:0]  id_pool[ID_POOL];
    int unsigned  idle_cycles;
    int unsigned  burst_left;
    int unsigned  stall_mode;
    int unsigned  stall_phase;
    int unsigned  n_sent;

    order_table_with_sorted_snapshot_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .ord_key(ord_key), .price(price),
        .quantity(quantity), .side(side),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .ord_key_res(ord_key_res), .price_res(price_res),
        .quantity_res(quantity_res), .side_res(side_res), .last(last),
        .active_count(active_count), .added_total(added_total),
        .cancelled_total(cancelled_total)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Result side: check transfers, stall in phases of varying pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            stall_phase <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                book.check_report('{status, ord_key_res, price_res, quantity_res,
                                    side_res, last, active_count, added_total,
                                    cancelled_total});
            if (stall_phase == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_phase <= $urandom_range(50, 400);
            end
            else
                stall_phase <= stall_phase - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one command transfer; valid stays high so back-to-back sends work
    task automatic send_command(logic [2:0] cmd, logic [63:0] key, logic [31:0] pr,
                                logic [31:0] qty, logic sd);
        in_valid <= 1'b1;
        command <= cmd;
        ord_key <= key;
        price <= pr;
        quantity <= qty;
        side <= sd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        book.note_command(cmd, key, pr, qty, sd);
        n_sent++;
    endtask

    // sender bursts with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        else
            burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending_reports.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_price();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return 1000 + $urandom_range(0, 5);
        endcase
    endfunction

    task automatic send_random_add();
        send_command(CMD_ADD, id_pool[$urandom_range(0, ID_POOL-1)], pick_price(),
                     $urandom(), $urandom_range(0, 1));
    endtask

    task automatic send_random_item();
        int pick;
        logic [63:0] key;
        pick = $urandom_range(0, 99);
        key = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
                                          : id_pool[$urandom_range(0, ID_POOL-1)];
        if (pick < 45)
            send_command(CMD_ADD, key, pick_price(), $urandom(), $urandom_range(0, 1));
        else if (pick < 70)
            send_command(CMD_CANCEL, key, $urandom(), $urandom(), $urandom_range(0, 1));
        else if (pick < 92)
            send_command(CMD_GET, key, $urandom(), $urandom(), $urandom_range(0, 1));
        else if (pick < 95)
            send_command(CMD_SNAPSHOT, key, $urandom(), $urandom(), $urandom_range(0, 1));
        else if (pick < 97)
            send_command(CMD_CLEAR, key, $urandom(), $urandom(), $urandom_range(0, 1));
        else
            send_command(3'($urandom_range(5, 7)), key, $urandom(), $urandom(),
                         $urandom_range(0, 1));
    endtask

    initial
    begin
        book = new();
        idle_cycles = 0;
        burst_left = 0;
        n_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_GET;
        ord_key = '0;
        price = '0;
        quantity = '0;
        side = 1'b0;
        foreach (id_pool[i])
            id_pool[i] = (i < 8) ? 64'(i) : {$urandom(), $urandom()};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, field extremes, duplicates, ties, spare codes
        send_command(CMD_SNAPSHOT, '0, '0, '0, 1'b0);
        send_command(CMD_GET, 64'd5, '0, '0, 1'b0);
        send_command(CMD_CANCEL, 64'd5, '0, '0, 1'b0);
        send_command(CMD_ADD, '0, '0, '0, 1'b0);
        send_command(CMD_ADD, '1, '1, '1, 1'b1);
        send_command(CMD_ADD, '1, 32'd7, 32'd7, 1'b0);
        send_command(CMD_ADD, 64'd9, 32'd500, 32'd1, 1'b0);
        send_command(CMD_ADD, 64'd3, 32'd500, 32'd2, 1'b0);
        send_command(CMD_ADD, 64'd4, 32'd500, 32'd3, 1'b1);
        send_command(CMD_ADD, 64'd2, 32'd500, 32'd4, 1'b1);
        send_command(CMD_GET, '1, '0, '0, 1'b0);
        send_command(CMD_GET, '0, '0, '0, 1'b0);
        send_command(CMD_SNAPSHOT, '0, '0, '0, 1'b0);
        send_command(CMD_CANCEL, '0, '0, '0, 1'b0);
        send_command(CMD_ADD, 64'd1, 32'd600, 32'd5, 1'b0);
        send_command(3'd5, '1, '1, '1, 1'b1);
        send_command(3'd6, '0, '0, '0, 1'b0);
        send_command(3'd7, '1, '1, '1, 1'b1);
        send_command(CMD_SNAPSHOT, '0, '0, '0, 1'b0);
        send_command(CMD_CLEAR, '0, '0, '0, 1'b0);
        send_command(CMD_GET, 64'd9, '0, '0, 1'b0);
        send_command(CMD_SNAPSHOT, '0, '0, '0, 1'b0);
        wait_drained();

        // Fill the table to capacity, then duplicate and overflow adds
        for (int i = 0; i < CAPACITY; i++)
        begin
            pace_sender();
            send_command(CMD_ADD, id_pool[i], pick_price(), $urandom(), $urandom_range(0, 1));
        end
        send_command(CMD_ADD, id_pool[3], '0, '0, 1'b0);
        send_command(CMD_ADD, id_pool[CAPACITY], '1, '1, 1'b1);
        send_command(CMD_SNAPSHOT, '0, '0, '0, 1'b0);
        send_command(CMD_CANCEL, id_pool[10], '0, '0, 1'b0);
        send_command(CMD_ADD, id_pool[CAPACITY+1], 32'd1000, 32'd9, 1'b1);
        wait_drained();

        // Random traffic, with an occasional full drain of the results
        for (int i = 0; i < 420; i++)
        begin
            pace_sender();
            if ($urandom_range(0, 59) == 0)
                wait_drained();
            if ($urandom_range(0, 3) == 0)
                send_random_add();
            else
                send_random_item();
        end
        wait_drained();

        // Refill to full once more and take a full-size snapshot
        for (int i = 0; i < CAPACITY + 4; i++)
        begin
            pace_sender();
            send_random_add();
        end
        send_command(CMD_SNAPSHOT, '0, '0, '0, 1'b0);
        wait_drained();
        repeat (300) @(posedge clk);

        $display("tb: %0d commands sent, %0d results checked, %0d snapshot rows",
                 n_sent, book.n_checked, book.n_snap_rows);
        $display("tb: %0d full-table adds and %0d duplicate adds seen",
                 book.n_full_seen, book.n_dup_seen);
        if (book.mismatches == 0 && book.pending_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
